// File: hdl/circle_point_generator_assert.svh
// assertion macros for the circle point generator rtl
// no dependencies; files take this header by include
`ifndef CIRCLE_POINT_GENERATOR_ASSERT_SVH
`define CIRCLE_POINT_GENERATOR_ASSERT_SVH

// same-cycle implication
`define CPG_ASSERT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("circle point generator: check failed");

// next-cycle implication
`define CPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("circle point generator: check failed");

`endif

// File: hdl/cpg_pkg.sv
// types and constants of the circle point generator
// no dependencies; used by every module of the block
`default_nettype none

package cpg_pkg;

  localparam int FIELD_BITS = 16;
  localparam int DEC_BITS   = 20;
  localparam int GROUP_SIZE = 8;
  localparam int IDX_BITS   = $clog2(GROUP_SIZE);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS  = $clog2(QUEUE_DEPTH + 1);

  // point index bits: bit 0 negates x, bit 1 negates y, bit 2 swaps offsets
  localparam int NEG_X_BIT = 0;
  localparam int NEG_Y_BIT = 1;
  localparam int SWAP_BIT  = 2;
  localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(GROUP_SIZE - 1);

  // midpoint decision constants
  localparam logic [DEC_BITS-1:0] DEC_INIT    = DEC_BITS'(3);
  localparam logic [DEC_BITS-1:0] DEC_ADD_NEG = DEC_BITS'(6);
  localparam logic [DEC_BITS-1:0] DEC_ADD_POS = DEC_BITS'(10);

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                 kind;
    logic [FIELD_BITS-1:0] center_x;
    logic [FIELD_BITS-1:0] center_y;
    logic [FIELD_BITS-1:0] radius;
    logic                  fill;
    logic [FIELD_BITS-1:0] color;
  } cpg_in_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] point_x;
    logic [FIELD_BITS-1:0] point_y;
    logic [FIELD_BITS-1:0] point_color;
    logic                  last_of_group;
    logic                  shape_done;
  } cpg_out_t;

  // one symmetric group, handed from the walker to the point emitter
  typedef struct packed {
    logic [FIELD_BITS-1:0] off_a;
    logic [FIELD_BITS-1:0] off_b;
    logic [FIELD_BITS-1:0] centre_col;
    logic [FIELD_BITS-1:0] centre_row;
    logic [FIELD_BITS-1:0] color;
    logic                  done;
  } grp_t;

endpackage

`default_nettype wire

// File: hdl/circle_point_generator.sv
// circle point generator: midpoint circle / filled disc point stream
// depends on cpg_pkg, cpg_front, cpg_queue and cpg_back
//
// input channel (push_i / full_o, payload in_item_i): a start item loads
// center, radius, fill flag and color and gives no points; each step item
// gives one group of eight symmetric points. a step while idle gives
// nothing. a start abandons the shape being walked; groups already queued
// are still delivered.
// result channel (empty_o / pop_i, payload out_item_o): one point per beat,
// last_of_group on the eighth point, shape_done on the last point of shape.
// a step's group is registered in the group queue, then its first point in
// the point output register before it is on the ports. throughput: one
// point per cycle while groups wait and the receiver pops; the single point
// output register and the eight-point expansion of each group set that figure.
// the walker takes a step per cycle while the two-entry group queue has room,
// so full_o rises when the receiver stalls or steps come faster than groups
// drain. reset: queue empties, the walker goes idle, no result is shown.
`default_nettype none

module circle_point_generator #(
  parameter int COORD_BITS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  output logic                  full_o,
  input  wire cpg_pkg::cpg_in_t in_item_i,
  output logic                  empty_o,
  input  wire logic             pop_i,
  output cpg_pkg::cpg_out_t     out_item_o
);
  import cpg_pkg::*;

  grp_t grp_in, grp_head;
  logic grp_push, grp_full, grp_pop, grp_empty;

  cpg_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .item_i     (in_item_i),
    .full_o     (full_o),
    .grp_push_o (grp_push),
    .grp_o      (grp_in),
    .grp_full_i (grp_full)
  );

  cpg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (grp_push),
    .data_i  (grp_in),
    .full_o  (grp_full),
    .pop_i   (grp_pop),
    .empty_o (grp_empty),
    .data_o  (grp_head)
  );

  cpg_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_i       (grp_head),
    .grp_empty_i (grp_empty),
    .grp_pop_o   (grp_pop),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .item_o      (out_item_o)
  );

endmodule

`default_nettype wire

// File: hdl/cpg_front.sv
// front end: accepts start/step items and walks the midpoint circle
// depends on cpg_pkg; pushes one grp_t into the group queue per step of a running shape
`default_nettype none

module cpg_front #(
  parameter int COORD_BITS = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire cpg_pkg::cpg_in_t item_i,
  output logic                 full_o,
  output logic                 grp_push_o,
  output cpg_pkg::grp_t        grp_o,
  input  wire logic            grp_full_i
);
  import cpg_pkg::*;

  localparam int CW = COORD_BITS;

  logic [CW-1:0]       col_q, col_d, row_q, row_d;
  logic [CW-1:0]       a_q, a_d, b_q, b_d, inner_q, inner_d;
  logic [DEC_BITS-1:0] dec_q, dec_d;
  logic                fill_q, fill_d, run_q, run_d;
  logic [FIELD_BITS-1:0] color_q, color_d;

  logic                accept;
  logic [CW:0]         a_x, b_x, na, nb, inner_inc;
  logic [DEC_BITS-1:0] a_w, b_w, r_w, dec_n;
  logic [CW-1:0]       r_c, grp_b;
  logic                more, done;

  assign accept = push_i && !grp_full_i;
  assign full_o = grp_full_i;

  assign a_x = {1'b0, a_q};
  assign b_x = {1'b0, b_q};
  assign a_w = {{(DEC_BITS - CW){1'b0}}, a_q};
  assign b_w = {{(DEC_BITS - CW){1'b0}}, b_q};
  assign r_c = item_i.radius[CW-1:0];
  assign r_w = {{(DEC_BITS - CW){1'b0}}, r_c};
  assign inner_inc = {1'b0, inner_q} + (CW + 1)'(1);
  assign more = inner_inc < b_x;

  // one midpoint update
  always_comb begin
    na = a_x + (CW + 1)'(1);
    if (dec_q[DEC_BITS-1]) begin
      dec_n = dec_q + (a_w << 2) + DEC_ADD_NEG;
      nb    = b_x;
    end else begin
      dec_n = dec_q + ((a_w - b_w) << 2) + DEC_ADD_POS;
      nb    = (b_q == '0) ? '0 : b_x - (CW + 1)'(1);
    end
  end

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    a_d     = a_q;
    b_d     = b_q;
    inner_d = inner_q;
    dec_d   = dec_q;
    fill_d  = fill_q;
    run_d   = run_q;
    color_d = color_q;
    done    = 1'b0;
    grp_b   = fill_q ? inner_q : b_q;
    grp_push_o = 1'b0;
    if (accept) begin
      unique case (item_i.kind)
        KIND_START: begin
          col_d   = item_i.center_x[CW-1:0];
          row_d   = item_i.center_y[CW-1:0];
          a_d     = '0;
          b_d     = r_c;
          inner_d = '0;
          dec_d   = DEC_INIT - (r_w << 1);
          fill_d  = item_i.fill;
          color_d = item_i.color;
          run_d   = !(item_i.fill && (r_c == '0));
        end
        KIND_STEP: begin
          if (run_q) begin
            grp_push_o = 1'b1;
            if (!fill_q) begin
              done  = na > nb;
              a_d   = na[CW-1:0];
              b_d   = nb[CW-1:0];
              dec_d = dec_n;
            end else if (more) begin
              inner_d = inner_inc[CW-1:0];
            end else begin
              done  = na >= nb;
              a_d   = na[CW-1:0];
              b_d   = nb[CW-1:0];
              dec_d = dec_n;
              if (!done) begin
                inner_d = na[CW-1:0];
              end
            end
            run_d = !done;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    grp_o.off_a      = FIELD_BITS'(a_q);
    grp_o.off_b      = FIELD_BITS'(grp_b);
    grp_o.centre_col = FIELD_BITS'(col_q);
    grp_o.centre_row = FIELD_BITS'(row_q);
    grp_o.color      = color_q;
    grp_o.done       = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else begin
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q   <= col_d;
    row_q   <= row_d;
    a_q     <= a_d;
    b_q     <= b_d;
    inner_q <= inner_d;
    dec_q   <= dec_d;
    fill_q  <= fill_d;
    color_q <= color_d;
  end

endmodule

`default_nettype wire

// File: hdl/cpg_queue.sv
// short queue of point groups between walker and emitter
// depends on cpg_pkg for grp_t and the queue depth
`default_nettype none

module cpg_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire cpg_pkg::grp_t data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output cpg_pkg::grp_t      data_o
);
  import cpg_pkg::*;

  grp_t                 mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_BITS-1:0] cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign full_o  = cnt_q == QCNT_BITS'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? wr_q + QPTR_BITS'(1) : wr_q;
    rd_d  = do_pop ? rd_q + QPTR_BITS'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: hdl/cpg_back.sv
// back end: eight points per head group, one per cycle unless stalled
// depends on cpg_pkg and circle_point_generator_assert.svh
`default_nettype none
`include "circle_point_generator_assert.svh"

module cpg_back #(
  parameter int COORD_BITS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cpg_pkg::grp_t grp_i,
  input  wire logic          grp_empty_i,
  output logic               grp_pop_o,
  output logic               empty_o,
  input  wire logic          pop_i,
  output cpg_pkg::cpg_out_t  item_o
);
  import cpg_pkg::*;

  localparam int CW = COORD_BITS;

  logic [IDX_BITS-1:0] idx_q;
  logic                out_valid_q;
  cpg_out_t            out_q, out_d;
  logic                load;
  logic [CW-1:0]       cx, cy, dx, dy, px, py;

  assign load      = !grp_empty_i && (!out_valid_q || pop_i);
  assign grp_pop_o = load && (idx_q == IDX_LAST);
  assign empty_o   = !out_valid_q;
  assign item_o    = out_q;

  assign cx = grp_i.centre_col[CW-1:0];
  assign cy = grp_i.centre_row[CW-1:0];
  // upper half of the group swaps the two offsets
  assign dx = idx_q[SWAP_BIT] ? grp_i.off_b[CW-1:0] : grp_i.off_a[CW-1:0];
  assign dy = idx_q[SWAP_BIT] ? grp_i.off_a[CW-1:0] : grp_i.off_b[CW-1:0];
  assign px = idx_q[NEG_X_BIT] ? cx - dx : cx + dx;
  assign py = idx_q[NEG_Y_BIT] ? cy - dy : cy + dy;

  always_comb begin
    out_d.point_x       = FIELD_BITS'(px);
    out_d.point_y       = FIELD_BITS'(py);
    out_d.point_color   = grp_i.color;
    out_d.last_of_group = idx_q == IDX_LAST;
    out_d.shape_done    = (idx_q == IDX_LAST) && grp_i.done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q       <= idx_q + IDX_BITS'(1);
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  // a group stays at the queue head until its last point is loaded
  `CPG_ASSERT(a_grp_held, clk_i, rst_ni, idx_q != '0, !grp_empty_i)
  `CPG_ASSERT_NEXT(a_idx_stall, clk_i, rst_ni, out_valid_q && !pop_i, $stable(idx_q))
  `CPG_ASSERT(a_done_last, clk_i, rst_ni, out_valid_q && out_q.shape_done, out_q.last_of_group)

endmodule

`default_nettype wire

// File: verif/circle_point_generator_check.sv
// scoreboard for the circle point generator: watches both queue channels,
// predicts every point beat from accepted items and compares in order
// depends on cpg_pkg for the channel payload types
module circle_point_generator_check (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              full_i,
  input  cpg_pkg::cpg_in_t  in_item_i,
  input  logic              empty_i,
  input  logic              pop_i,
  input  cpg_pkg::cpg_out_t out_item_i,
  output int                fail_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import cpg_pkg::*;

  logic [15:0] ctr_col, ctr_row;
  logic [15:0] walk_x, walk_y, fill_y;
  logic [19:0] decision;
  logic        fill_mode, walking;
  logic [15:0] shade;

  cpg_out_t point_queue[$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // midpoint update; returns the new offsets before wrapping, y floored at 0
  task automatic advance_midpoint(output int next_x, output int next_y);
    longint d, a, b;
    d = $signed(decision);
    a = walk_x;
    b = walk_y;
    if (d < 0) begin
      d = d + 4 * a + 6;
    end else begin
      d = d + 4 * (a - b) + 10;
      b = b - 1;
    end
    a = a + 1;
    decision = d[19:0];
    next_x = int'(a);
    next_y = (b < 0) ? 0 : int'(b);
    walk_x = a[15:0];
    walk_y = b[15:0];
  endtask

  task automatic queue_group(input logic [15:0] a, input logic [15:0] b, input logic done);
    logic [15:0] dx, dy;
    logic [2:0]  idx;
    cpg_out_t    pt;
    for (int k = 0; k < 8; k++) begin
      idx = 3'(k);
      dx  = idx[SWAP_BIT] ? b : a;
      dy  = idx[SWAP_BIT] ? a : b;
      pt.point_x       = idx[NEG_X_BIT] ? ctr_col - dx : ctr_col + dx;
      pt.point_y       = idx[NEG_Y_BIT] ? ctr_row - dy : ctr_row + dy;
      pt.point_color   = shade;
      pt.last_of_group = (k == 7);
      pt.shape_done    = (k == 7) && done;
      point_queue.push_back(pt);
    end
  endtask

  task automatic predict_points(input cpg_in_t it);
    logic [15:0] a, b;
    int          nx, ny;
    logic        done;
    if (it.kind == KIND_START) begin
      ctr_col   = it.center_x;
      ctr_row   = it.center_y;
      fill_mode = it.fill;
      shade     = it.color;
      walk_x    = '0;
      walk_y    = it.radius;
      fill_y    = '0;
      decision  = 20'(3 - 2 * longint'(it.radius));
      walking   = !(it.fill && it.radius == 16'd0);
    end else if (walking) begin
      done = 1'b0;
      a    = walk_x;
      if (!fill_mode) begin
        b = walk_y;
        advance_midpoint(nx, ny);
        done = (nx > ny);
      end else begin
        b = fill_y;
        if (int'(fill_y) + 1 < int'(walk_y)) begin
          fill_y = fill_y + 16'd1;
        end else begin
          // inner run exhausted: move to the next column
          advance_midpoint(nx, ny);
          if (nx >= ny) done = 1'b1;
          else fill_y = nx[15:0];
        end
      end
      queue_group(a, b, done);
      if (done) walking = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cpg_out_t want;
    if (!rst_ni) begin
      ctr_col   = '0;
      ctr_row   = '0;
      walk_x    = '0;
      walk_y    = '0;
      fill_y    = '0;
      decision  = '0;
      fill_mode = 1'b0;
      walking   = 1'b0;
      shade     = '0;
      point_queue.delete();
      pending_o = 0;
    end else begin
      if (push_i && !full_i) predict_points(in_item_i);
      if (pop_i && !empty_i) begin
        if (point_queue.size() == 0) begin
          $error("point beat with nothing expected: x %0h y %0h",
                 out_item_i.point_x, out_item_i.point_y);
          fail_count_o++;
        end else begin
          want = point_queue.pop_front();
          check_field("point_x", want.point_x, out_item_i.point_x);
          check_field("point_y", want.point_y, out_item_i.point_y);
          check_field("point_color", want.point_color, out_item_i.point_color);
          check_field("last_of_group", 16'(want.last_of_group),
                      16'(out_item_i.last_of_group));
          check_field("shape_done", 16'(want.shape_done), 16'(out_item_i.shape_done));
        end
      end
      pending_o = point_queue.size();
    end
  end

endmodule

// File: verif/circle_point_generator_test.sv
// top of the circle point generator testbench: clock, reset, item stimulus,
// random receiver stalls and the verdict
// depends on cpg_pkg, circle_point_generator and circle_point_generator_check
module circle_point_generator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cpg_pkg::*;

  localparam int PHASE_ITEMS = 78;

  logic     clk_i;
  logic     rst_ni    = 1'b0;
  logic     push_i    = 1'b0;
  logic     pop_i     = 1'b0;
  cpg_in_t  in_item_i = '0;
  logic     full_o, empty_o;
  cpg_out_t out_item_o;
  int       fail_count, pending;
  int       idle_pct  = 0;
  int       stall_pct = 0;
  int       items_sent = 0;

  circle_point_generator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .full_o     (full_o),
    .in_item_i  (in_item_i),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .out_item_o (out_item_o)
  );

  circle_point_generator_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .full_i       (full_o),
    .in_item_i    (in_item_i),
    .empty_i      (empty_o),
    .pop_i        (pop_i),
    .out_item_i   (out_item_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk_i) begin
    pop_i <= ($urandom_range(99) >= stall_pct);
  end

  function automatic cpg_in_t start_item(logic [15:0] cx, logic [15:0] cy, logic [15:0] rad,
                                         logic fl, logic [15:0] col);
    cpg_in_t it;
    it.kind     = KIND_START;
    it.center_x = cx;
    it.center_y = cy;
    it.radius   = rad;
    it.fill     = fl;
    it.color    = col;
    return it;
  endfunction

  // fields other than kind are ignored on a step, so they carry junk
  function automatic cpg_in_t step_item();
    cpg_in_t it;
    it.kind     = KIND_STEP;
    it.center_x = 16'($urandom);
    it.center_y = 16'($urandom);
    it.radius   = 16'($urandom);
    it.fill     = 1'($urandom_range(1));
    it.color    = 16'($urandom);
    return it;
  endfunction

  task automatic send_item(input cpg_in_t it);
    while ($urandom_range(99) < idle_pct) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i    <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (full_o);
    items_sent++;
  endtask

  task automatic run_shape(input cpg_in_t first, input int steps);
    send_item(first);
    repeat (steps) send_item(step_item());
  endtask

  task automatic random_sequence();
    cpg_in_t noise;
    int      rad, steps;
    logic    fl;
    if ($urandom_range(99) < 15) begin
      noise      = step_item();
      noise.kind = kind_e'($urandom_range(1));
      send_item(noise);
    end else begin
      fl = 1'($urandom_range(1));
      case ($urandom_range(19))
        0:       rad = 0;
        1:       rad = int'($urandom_range(65535, 25));
        default: rad = fl ? int'($urandom_range(9, 1)) : int'($urandom_range(24, 1));
      endcase
      if (rad > 24) steps = int'($urandom_range(6, 1));
      else steps = fl ? rad * rad * 2 / 5 + 2 : rad * 3 / 4 + 2;
      // cut some shapes short so the next start abandons them
      if ($urandom_range(3) == 0) steps = int'($urandom_range(steps, 1));
      run_shape(start_item(16'($urandom), 16'($urandom), 16'(rad), fl, 16'($urandom)),
                steps);
    end
  endtask

  initial begin
    int target;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle step, zero radius both modes, wrap at both ends,
    // full outline and fill walks, abandoned large circles
    send_item(step_item());
    run_shape(start_item(16'h0000, 16'h0000, 16'h0000, 1'b0, 16'hffff), 2);
    run_shape(start_item(16'h4000, 16'h4000, 16'h0000, 1'b1, 16'h0000), 1);
    run_shape(start_item(16'hffff, 16'hffff, 16'd3, 1'b0, 16'h0000), 3);
    run_shape(start_item(16'h8000, 16'h0000, 16'd2, 1'b1, 16'hffff), 3);
    run_shape(start_item(16'h1234, 16'hfedc, 16'hffff, 1'b0, 16'ha5a5), 3);
    run_shape(start_item(16'hffff, 16'h0000, 16'hffff, 1'b1, 16'h5a5a), 2);
    run_shape(start_item(16'h0001, 16'hfffe, 16'd5, 1'b0, 16'h07e0), 5);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 60; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) random_sequence();
    end
    push_i <= 1'b0;

    do @(negedge clk_i); while (pending != 0);
    repeat (16) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
